/* rtl/bitmap_rotate_90_1bpp_core_assert.svh */
// Assertion macros for the rotating frame store.
`ifndef BITMAP_ROTATE_90_1BPP_CORE_ASSERT_SVH
`define BITMAP_ROTATE_90_1BPP_CORE_ASSERT_SVH

// Same-cycle implication.
`define BRR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/brr_pkg.sv */
// Shared types and constants for the rotating 1bpp frame store.
`timescale 1ns / 1ps

package brr_pkg;

  localparam int LANES  = 8;
  localparam int ROW_W  = 10;
  localparam int BCOL_W = 7;
  localparam int BYTE_W = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [BYTE_W-1:0] WHITE_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] MSB_MASK   = 8'h80;

  // One captured input item.
  typedef struct packed {
    logic              command;
    logic [ROW_W-1:0]  row;
    logic [BCOL_W-1:0] byte_column;
    logic [BYTE_W-1:0] pixel_byte;
  } item_t;

  // Sequencer strobes to every lane.
  typedef struct packed {
    logic clr;   // clearing pass write
    logic calc;  // latch lane address and bit
    logic rd;    // issue RAM read
    logic wr;    // write back modified byte
    logic ok;    // item is in range
  } lane_ctl_t;

endpackage

/* rtl/bitmap_rotate_90_1bpp_core.sv */
// Top level: 1bpp frame store that rotates portrait writes into native landscape bytes.
// An item is taken, then goes calc, RAM read, finish; finish loads a read result into out_*.
// A new item is taken only once the previous one has left finish; in_stall is high till then.
// A write updates all 8 native bytes at once: eight banks, one per native row mod 8.
// Reset: synchronous, active low; a clearing pass over all ceil(W/8)*ceil(H/8) addresses
// (6000 at defaults) whites every bank while in_stall stays high.
`timescale 1ns / 1ps
`include "bitmap_rotate_90_1bpp_core_assert.svh"

module bitmap_rotate_90_1bpp_core #(
  parameter int PORTRAIT_WIDTH  = 480,
  parameter int PORTRAIT_HEIGHT = 800
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [brr_pkg::ROW_W-1:0]   in_row,
  input  logic [brr_pkg::BCOL_W-1:0]  in_byte_column,
  input  logic [brr_pkg::BYTE_W-1:0]  in_pixel_byte,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brr_pkg::BYTE_W-1:0]  out_read_byte
);

  import brr_pkg::*;

  localparam int LANE_ROWS    = (PORTRAIT_WIDTH + 7) / 8;
  localparam int NATIVE_BYTES = (PORTRAIT_HEIGHT + 7) / 8;
  localparam int LANE_DEPTH   = LANE_ROWS * NATIVE_BYTES;
  localparam int AW           = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(LANE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CALC  = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  item_t             item_r;
  logic              ok_r, ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_read_byte_r;
  logic              in_xfer;
  logic              out_free;
  logic              load_out;
  logic              clr_done;
  lane_ctl_t         ctl;
  logic [BYTE_W-1:0] lane_bytes [LANES];
  logic [BYTE_W-1:0] merged;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  // output register empty, or emptying this cycle
  assign out_free = !out_valid_r || !out_stall;
  // last address of the clearing pass
  assign clr_done = (state_r == S_CLEAR) && (clr_cnt_r == CLR_LAST);

  // Range check at capture: writes against the portrait frame, reads against the native one.
  always_comb begin
    if (in_command == CMD_WRITE) begin
      ok_nxt = ({1'b0, in_row} < 11'(PORTRAIT_HEIGHT)) &&
               ({1'b0, in_byte_column} < 8'(LANE_ROWS));
    end else begin
      ok_nxt = ({1'b0, in_row} < 11'(PORTRAIT_WIDTH)) &&
               ({1'b0, in_byte_column} < 8'(NATIVE_BYTES));
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    ctl         = '0;
    ctl.ok      = ok_r;
    load_out    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.clr     = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        ctl.calc  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (item_r.command == CMD_WRITE) begin
          ctl.wr    = 1'b1;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          // RAM read data holds until taken
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.command     <= in_command;
      item_r.row         <= in_row;
      item_r.byte_column <= in_byte_column;
      item_r.pixel_byte  <= in_pixel_byte;
      ok_r               <= ok_nxt;
    end
    if (load_out) begin
      out_read_byte_r <= merged;
    end
  end

  // Eight banks, each owns native rows with row mod 8 equal to its index.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    brr_lane #(
      .LANE           (k),
      .PORTRAIT_WIDTH (PORTRAIT_WIDTH),
      .PORTRAIT_HEIGHT(PORTRAIT_HEIGHT)
    ) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .item    (item_r),
      .clr_addr(clr_cnt_r),
      .rd_byte (lane_bytes[k])
    );
  end

  brr_merge u_merge (
    .lane_bytes(lane_bytes),
    .sel       (item_r.row[2:0]),
    .ok        (ok_r),
    .merged    (merged)
  );

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_read_byte_r;

  // Checks
  `BRR_ASSERT_NEXT(a_xfer_to_calc, clk, rst_n, in_xfer, state_r == S_CALC, "no calc")
  `BRR_ASSERT_NEXT(a_clear_ends, clk, rst_n, clr_done, state_r == S_IDLE, "clear did not end")
  `BRR_ASSERT_IMP(a_wr_only_write, clk, rst_n, ctl.wr, item_r.command == CMD_WRITE, "bad wr")
  `BRR_ASSERT_NEXT(a_read_result, clk, rst_n, load_out, out_valid_r, "read result not loaded")

endmodule

/* rtl/brr_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module brr_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/brr_lane.sv */
// One bank lane: native rows with row mod 8 equal to LANE, read-modify-write of one bit.
`timescale 1ns / 1ps

module brr_lane #(
  parameter  int LANE            = 0,
  parameter  int PORTRAIT_WIDTH  = 480,
  parameter  int PORTRAIT_HEIGHT = 800,
  localparam int LANE_ROWS       = (PORTRAIT_WIDTH + 7) / 8,
  localparam int NATIVE_BYTES    = (PORTRAIT_HEIGHT + 7) / 8,
  localparam int LANE_DEPTH      = LANE_ROWS * NATIVE_BYTES,
  localparam int AW              = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1
) (
  input  logic                     clk,
  input  brr_pkg::lane_ctl_t       ctl,
  input  brr_pkg::item_t           item,
  input  logic [AW-1:0]            clr_addr,
  output logic [brr_pkg::BYTE_W-1:0] rd_byte
);

  import brr_pkg::*;

  localparam logic [10:0] BASE_TOP = 11'(PORTRAIT_WIDTH - 1);
  localparam logic [AW-1:0] NB_A   = AW'(NATIVE_BYTES);

  logic [10:0]       base;
  logic [2:0]        sub;      // pixel index within the portrait byte
  logic [10:0]       nrow;
  logic              hit;
  logic [7:0]        lrow;
  logic [6:0]        col;
  logic [AW-1:0]     addr_nxt, addr_r;
  logic [BYTE_W-1:0] mask_nxt, mask_r;
  logic              wbit_nxt, wbit_r;
  logic              wen_nxt, wen_r;
  logic [BYTE_W-1:0] ram_q;
  logic [BYTE_W-1:0] mod_byte;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;

  // Portrait pixel x = 8*bcol + sub lands on native row W-1-x; pick the one for this bank.
  always_comb begin
    base = BASE_TOP - 11'({item.byte_column, 3'b000});
    sub  = base[2:0] - 3'(LANE);
    nrow = base - 11'(sub);
    hit  = (base >= 11'(sub));
    if (item.command == CMD_WRITE) begin
      lrow     = nrow[10:3];
      col      = item.row[9:3];
      wen_nxt  = ctl.ok && hit;
    end else begin
      lrow     = {1'b0, item.row[9:3]};
      col      = item.byte_column;
      wen_nxt  = 1'b0;
    end
    mask_nxt = MSB_MASK >> item.row[2:0];
    wbit_nxt = item.pixel_byte[3'd7 - sub];
    addr_nxt = ctl.ok ? AW'(AW'(lrow) * NB_A + AW'(col)) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      addr_r <= addr_nxt;
      mask_r <= mask_nxt;
      wbit_r <= wbit_nxt;
      wen_r  <= wen_nxt;
    end
  end

  assign mod_byte  = wbit_r ? (ram_q | mask_r) : (ram_q & ~mask_r);
  assign ram_we    = ctl.clr || (ctl.wr && wen_r);
  assign ram_waddr = ctl.clr ? clr_addr : addr_r;
  assign ram_wdata = ctl.clr ? WHITE_BYTE : mod_byte;

  brr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(LANE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ctl.rd),
    .raddr(addr_r),
    .rdata(ram_q)
  );

  assign rd_byte = ram_q;

endmodule

/* rtl/brr_merge.sv */
// Picks the bank that holds the read row; out-of-range reads give white.
`timescale 1ns / 1ps

module brr_merge (
  input  logic [brr_pkg::BYTE_W-1:0] lane_bytes [brr_pkg::LANES],
  input  logic [2:0]                 sel,
  input  logic                       ok,
  output logic [brr_pkg::BYTE_W-1:0] merged
);

  import brr_pkg::*;

  always_comb begin
    merged = ok ? lane_bytes[sel] : WHITE_BYTE;
  end

endmodule
